### rtl/jsap_pkg.sv
// ----------------------------------------------------------------------------
// jsap_pkg
// Types, character codes and state encodings shared by the JSON string array
// parser modules.
// ----------------------------------------------------------------------------
package jsap_pkg;

    // Character codes
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    // Decoded escape values
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [2:0] {
        PH_OPEN,
        PH_FIRST,
        PH_STRING,
        PH_ESCAPE,
        PH_AFTER_STR,
        PH_NEXT_STR,
        PH_TRAIL
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_UNEXPECT,
        ERR_CUT_ESC,
        ERR_BAD_ESC,
        ERR_UNTERM,
        ERR_TRAILING
    } err_t;

    typedef struct packed {
        phase_t     phase;
        logic       err_latched;
        err_t       err_value;
        logic       nonempty;
        logic       bad_char;
    } parse_state_t;

    localparam parse_state_t ST_RESET = '{
        phase:       PH_OPEN,
        err_latched: 1'b0,
        err_value:   ERR_NONE,
        nonempty:    1'b0,
        bad_char:    1'b0
    };

    typedef struct packed {
        logic [7:0] body_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_value;
        logic       string_end;
        logic       string_usable;
        logic       body_done;
        logic       body_ok;
        logic [2:0] error_code;
    } out_item_t;

endpackage

### rtl/jsap_step.sv
// ----------------------------------------------------------------------------
// jsap_step
// One parse step: current state and one body byte in, next state and the
// result of that byte out. Purely combinational.
// ----------------------------------------------------------------------------
module jsap_step
    import jsap_pkg::*;
(
    input  parse_state_t st,
    input  in_item_t     item,
    output parse_state_t st_next,
    output out_item_t    res
);

    logic [7:0] c;
    logic       is_ws;
    logic       esc_good;
    logic [7:0] esc_char;
    logic       take;
    logic [7:0] take_val;
    parse_state_t st_mid;
    out_item_t  res_mid;
    err_t       code;

    assign c = item.body_byte;

    // Classify the byte
    always_comb
    begin
        is_ws = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    end

    // Decode an escape letter
    always_comb
    begin
        esc_good = 1'b1;
        esc_char = c;
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_char = c;
            CH_B:    esc_char = CH_BS;
            CH_F:    esc_char = CH_FF;
            CH_N:    esc_char = CH_LF;
            CH_R:    esc_char = CH_CR;
            CH_T:    esc_char = CH_TAB;
            default:
            begin
                esc_good = 1'b0;
                esc_char = 8'h00;
            end
        endcase
    end

    // Advance the phase; latch the first error
    always_comb
    begin
        st_mid   = st;
        take     = 1'b0;
        take_val = c;
        res_mid  = '0;
        if (!st.err_latched)
        begin
            case (st.phase)
                PH_OPEN:
                begin
                    if (c == CH_LBRACK)
                        st_mid.phase = PH_FIRST;
                    else if (!is_ws)
                    begin
                        st_mid.err_latched = 1'b1;
                        st_mid.err_value   = ERR_UNEXPECT;
                    end
                end
                PH_FIRST, PH_NEXT_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        st_mid.phase    = PH_STRING;
                        st_mid.nonempty = 1'b0;
                        st_mid.bad_char = 1'b0;
                    end
                    else if (c == CH_RBRACK && st.phase == PH_FIRST)
                        st_mid.phase = PH_TRAIL;
                    else if (!is_ws)
                    begin
                        st_mid.err_latched = 1'b1;
                        st_mid.err_value   = ERR_UNEXPECT;
                    end
                end
                PH_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        res_mid.string_end    = 1'b1;
                        res_mid.string_usable = st.nonempty && !st.bad_char;
                        st_mid.phase          = PH_AFTER_STR;
                    end
                    else if (c == CH_BSLASH)
                        st_mid.phase = PH_ESCAPE;
                    else
                        take = 1'b1;
                end
                PH_ESCAPE:
                begin
                    if (esc_good)
                    begin
                        take         = 1'b1;
                        take_val     = esc_char;
                        st_mid.phase = PH_STRING;
                    end
                    else
                    begin
                        st_mid.err_latched = 1'b1;
                        st_mid.err_value   = ERR_BAD_ESC;
                    end
                end
                PH_AFTER_STR:
                begin
                    if (c == CH_RBRACK)
                        st_mid.phase = PH_TRAIL;
                    else if (c == CH_COMMA)
                        st_mid.phase = PH_NEXT_STR;
                    else if (!is_ws)
                    begin
                        st_mid.err_latched = 1'b1;
                        st_mid.err_value   = ERR_UNEXPECT;
                    end
                end
                PH_TRAIL:
                begin
                    if (!is_ws)
                    begin
                        st_mid.err_latched = 1'b1;
                        st_mid.err_value   = ERR_TRAILING;
                    end
                end
                default:
                begin
                    st_mid.err_latched = 1'b1;
                    st_mid.err_value   = ERR_UNEXPECT;
                end
            endcase
        end

        // Emit a decoded character and track string quality
        if (take)
        begin
            res_mid.char_valid = 1'b1;
            res_mid.char_value = take_val;
            st_mid.nonempty    = 1'b1;
            if (take_val <= CH_SPACE || take_val == CH_DEL)
                st_mid.bad_char = 1'b1;
        end
    end

    // Report on the final byte and return to the start state
    always_comb
    begin
        st_next = st_mid;
        res     = res_mid;
        code    = ERR_NONE;
        if (item.final_byte)
        begin
            if (st_mid.err_latched)
                code = st_mid.err_value;
            else
            begin
                case (st_mid.phase)
                    PH_TRAIL:                code = ERR_NONE;
                    PH_STRING, PH_AFTER_STR: code = ERR_UNTERM;
                    PH_ESCAPE:               code = ERR_CUT_ESC;
                    default:                 code = ERR_UNEXPECT;
                endcase
            end
            st_next = ST_RESET;
        end
        res.body_done  = item.final_byte;
        res.body_ok    = item.final_byte && (code == ERR_NONE);
        res.error_code = 3'(code);
    end

endmodule

### rtl/json_string_array_parser.sv
// ----------------------------------------------------------------------------
// json_string_array_parser
// Checks that a body is a JSON array of strings and streams out the decoded
// string characters, string ends and a final verdict per body.
//
//   channel  | direction | valid        | stall        | payload
//   ---------+-----------+--------------+--------------+-------------
//   byte     | in        | byte_valid   | byte_stall   | byte_item
//   result   | out       | result_valid | result_stall | result_item
//
// One byte per clock while the result channel does not stall; each accepted
// byte passes the input register and the parse step into the result register.
// The parser state updates when a byte moves from the input register into
// the result register, so each step sees the state left by the previous one.
// A waiting result does not block the input register from taking one more
// byte. Reset puts the parser in the start state with no error.
// ----------------------------------------------------------------------------
module json_string_array_parser
    import jsap_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result_item
);

    logic         s1_valid_reg;
    logic         s1_valid_next;
    in_item_t     s1_item_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    out_item_t    out_item_reg;
    parse_state_t st_reg;
    parse_state_t st_next;
    out_item_t    step_res;
    logic         advance;
    logic         take_in;

    // Handshake
    assign advance        = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall     = s1_valid_reg && !advance;
    assign take_in        = byte_valid && !byte_stall;
    assign s1_valid_next  = (s1_valid_reg && !advance) || take_in;
    assign out_valid_next = advance || (out_valid_reg && result_stall);

    // Parse one byte
    jsap_step u_step (
        .st      (st_reg),
        .item    (s1_item_reg),
        .st_next (st_next),
        .res     (step_res)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= ST_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                st_reg <= st_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
            s1_item_reg <= byte_item;
        if (advance)
            out_item_reg <= step_res;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    // Hold a latched error until the final byte of the body goes through
    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.err_latched && !(advance && s1_item_reg.final_byte))
        |=> st_reg.err_latched)
        else $error("latched error dropped before the end of the body");

    // Restart the parser after the final byte
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.final_byte)
        |=> (st_reg.phase == PH_OPEN && !st_reg.err_latched))
        else $error("parser did not restart after the final byte");

    // Accept a body only with no error code
    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.body_ok)
        |-> (result_item.body_done && result_item.error_code == 3'(ERR_NONE)))
        else $error("body accepted with an error code");

    // Never mark a character and a string end together
    a_char_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result_item.char_valid && result_item.string_end))
        else $error("character and string end in one transaction");

    // Hold the result register while it waits
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |=> (out_valid_reg && $stable(out_item_reg)))
        else $error("waiting result changed");

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for json_string_array_parser. Feeds response bodies one
// byte per transaction and compares every result transaction field by field against
// a built-in parser model or a fixed row expectation. A short directed table comes
// first, then random bodies, mostly well-formed arrays and partly broken ones.
// Both sides idle in random bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jsap_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 800;
    localparam int CALM_FROM     = 680;
    localparam int HOLD_OFF_AT   = 150;
    localparam int HOLD_OFF_LEN  = 60;

    typedef struct {
        in_item_t  item;
        bit        fixed;
        out_item_t want;
    } body_row_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      byte_valid   = 1'b0;
    logic      byte_stall;
    in_item_t  byte_item    = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result_item;

    // parser model state
    phase_t    model_phase;
    logic      model_err_latched;
    err_t      model_err_value;
    logic      model_nonempty;
    logic      model_bad_char;

    out_item_t predicted_results[$];
    body_row_t directed_rows[$];
    logic [7:0] body_q[$];

    int  random_sent    = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  calm_tail      = 1'b0;
    bit  quiet_body     = 1'b0;

    json_string_array_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    // 12 ns clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic bit is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_ctrl(logic [7:0] c);
        return (c < CH_SPACE) || (c == CH_DEL);
    endfunction

    function automatic void latch_error(err_t code);
        if (!model_err_latched)
        begin
            model_err_latched = 1'b1;
            model_err_value   = code;
        end
    endfunction

    function automatic void clear_parser();
        model_phase       = PH_OPEN;
        model_err_latched = 1'b0;
        model_err_value   = ERR_NONE;
        model_nonempty    = 1'b0;
        model_bad_char    = 1'b0;
    endfunction

    // Advance the model by one body byte and return the result it causes
    function automatic out_item_t parse_step(in_item_t it);
        out_item_t  res;
        logic [7:0] c;
        logic [7:0] emit_ch;
        bit         emit;
        err_t       code;
        res     = '0;
        c       = it.body_byte;
        emit    = 1'b0;
        emit_ch = '0;
        if (!model_err_latched)
        begin
            case (model_phase)
                PH_OPEN:
                begin
                    if (c == CH_LBRACK)
                        model_phase = PH_FIRST;
                    else if (!is_space(c))
                        latch_error(ERR_UNEXPECT);
                end
                PH_FIRST, PH_NEXT_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        model_phase    = PH_STRING;
                        model_nonempty = 1'b0;
                        model_bad_char = 1'b0;
                    end
                    else if (c == CH_RBRACK && model_phase == PH_FIRST)
                        model_phase = PH_TRAIL;
                    else if (!is_space(c))
                        latch_error(ERR_UNEXPECT);
                end
                PH_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        res.string_end    = 1'b1;
                        res.string_usable = model_nonempty && !model_bad_char;
                        model_phase       = PH_AFTER_STR;
                    end
                    else if (c == CH_BSLASH)
                        model_phase = PH_ESCAPE;
                    else
                    begin
                        emit    = 1'b1;
                        emit_ch = c;
                    end
                end
                PH_ESCAPE:
                begin
                    emit = 1'b1;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: emit_ch = c;
                        CH_B:    emit_ch = CH_BS;
                        CH_F:    emit_ch = CH_FF;
                        CH_N:    emit_ch = CH_LF;
                        CH_R:    emit_ch = CH_CR;
                        CH_T:    emit_ch = CH_TAB;
                        default: emit    = 1'b0;
                    endcase
                    if (emit)
                        model_phase = PH_STRING;
                    else
                        latch_error(ERR_BAD_ESC);
                end
                PH_AFTER_STR:
                begin
                    if (c == CH_RBRACK)
                        model_phase = PH_TRAIL;
                    else if (c == CH_COMMA)
                        model_phase = PH_NEXT_STR;
                    else if (!is_space(c))
                        latch_error(ERR_UNEXPECT);
                end
                PH_TRAIL:
                begin
                    if (!is_space(c))
                        latch_error(ERR_TRAILING);
                end
                default:
                    latch_error(ERR_UNEXPECT);
            endcase
        end

        // take a decoded character into the current string
        if (emit)
        begin
            res.char_valid = 1'b1;
            res.char_value = emit_ch;
            model_nonempty = 1'b1;
            if (is_ctrl(emit_ch) || is_space(emit_ch))
                model_bad_char = 1'b1;
        end

        // close the body on the final byte
        if (it.final_byte)
        begin
            if (model_err_latched)
                code = model_err_value;
            else
            begin
                case (model_phase)
                    PH_TRAIL:     code = ERR_NONE;
                    PH_STRING:    code = ERR_UNTERM;
                    PH_AFTER_STR: code = ERR_UNTERM;
                    PH_ESCAPE:    code = ERR_CUT_ESC;
                    default:      code = ERR_UNEXPECT;
                endcase
            end
            res.body_done  = 1'b1;
            res.body_ok    = (code == ERR_NONE);
            res.error_code = code;
            clear_parser();
        end
        return res;
    endfunction

    function automatic out_item_t verdict(err_t code);
        out_item_t v;
        v            = '0;
        v.body_done  = 1'b1;
        v.body_ok    = (code == ERR_NONE);
        v.error_code = code;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Byte channel
    // ------------------------------------------------------------------------
    task automatic add_row(logic [7:0] b, logic fin, bit fixed, out_item_t want);
        body_row_t row;
        row.item.body_byte  = b;
        row.item.final_byte = fin;
        row.fixed           = fixed;
        row.want            = want;
        directed_rows = {directed_rows, row};
    endtask

    // Offer one byte, hold it until taken, then record its expected result
    task automatic offer_byte(logic [7:0] b, logic fin, bit fixed, out_item_t want);
        in_item_t  it;
        out_item_t guess;
        it.body_byte  = b;
        it.final_byte = fin;
        if (!calm_tail && !quiet_body && $urandom_range(0, 5) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        do
            @(posedge clk);
        while (byte_stall);
        guess = parse_step(it);
        predicted_results = {predicted_results, (fixed ? want : guess)};
    endtask

    // Append one byte to the body under construction
    function automatic void append_byte(logic [7:0] b);
        body_q = {body_q, b};
    endfunction

    function automatic logic [7:0] pick_space();
        logic [7:0] s;
        s = 8'($urandom_range(0, 5));
        return (s == 5) ? CH_SPACE : CH_TAB + s;
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(0, 7))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic void add_gap(int most);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, most)) append_byte(pick_space());
    endfunction

    // Build one body: mostly well-formed arrays, the rest broken or noise
    task automatic build_body();
        int         kind;
        int         n_str;
        int         n_chr;
        int         idx;
        int         r;
        bit         plain;
        logic [7:0] ch;
        body_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
            return;
        end
        add_gap(2);
        append_byte(CH_LBRACK);
        n_str = $urandom_range(0, 4);
        for (int s = 0; s < n_str; s++)
        begin
            if (s > 0)
            begin
                add_gap(2);
                append_byte(CH_COMMA);
            end
            add_gap(2);
            append_byte(CH_QUOTE);
            plain = 1'($urandom_range(0, 1));
            n_chr = $urandom_range(0, 6);
            for (int k = 0; k < n_chr; k++)
            begin
                r = plain ? 0 : $urandom_range(0, 99);
                if (r < 50)
                begin
                    ch = 8'($urandom_range(8'h21, 8'h7E));
                    if (ch == CH_QUOTE || ch == CH_BSLASH)
                        ch = "A";
                    append_byte(ch);
                end
                else if (r < 65)
                begin
                    append_byte(CH_BSLASH);
                    append_byte(pick_escape());
                end
                else if (r < 80)
                begin
                    ch = 8'($urandom_range(0, 255));
                    if (ch == CH_QUOTE || ch == CH_BSLASH)
                        ch = 8'h80;
                    append_byte(ch);
                end
                else
                begin
                    ch = 8'($urandom_range(0, 33));
                    append_byte((ch == 33) ? CH_DEL : ch);
                end
            end
            append_byte(CH_QUOTE);
        end
        add_gap(2);
        append_byte(CH_RBRACK);
        add_gap(2);

        // break a quarter of the arrays
        if (kind >= 75)
        begin
            idx = $urandom_range(0, body_q.size() - 1);
            case ($urandom_range(0, 3))
                0:
                begin
                    r = $urandom_range(1, body_q.size());
                    while (body_q.size() > r)
                        void'(body_q.pop_back());
                end
                1: body_q[idx] = 8'($urandom_range(0, 255));
                2:
                begin
                    body_q[idx] = CH_BSLASH;
                    if (idx + 1 < body_q.size())
                        body_q[idx + 1] = 8'($urandom_range(0, 255));
                end
                default: append_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Result channel: stall in bursts, hold off once for a long stretch
    // ------------------------------------------------------------------------
    initial
    begin
        bit hold_off_pending;
        hold_off_pending = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_off_pending && random_sent >= HOLD_OFF_AT)
            begin
                hold_off_pending = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_OFF_LEN) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 6) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, result_item);
                mismatch_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("char_valid", want.char_valid, result_item.char_valid);
                check_field("char_value", want.char_value, result_item.char_value);
                check_field("string_end", want.string_end, result_item.string_end);
                check_field("string_usable", want.string_usable, result_item.string_usable);
                check_field("body_done", want.body_done, result_item.body_done);
                check_field("body_ok", want.body_ok, result_item.body_ok);
                check_field("error_code", want.error_code, result_item.error_code);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("json_string_array_parser regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        out_item_t w;
        clear_parser();

        // empty array
        add_row(CH_LBRACK, 1'b0, 1'b1, '0);
        add_row(CH_RBRACK, 1'b1, 1'b1, verdict(ERR_NONE));
        // whitespace-only body
        add_row(CH_SPACE, 1'b1, 1'b1, verdict(ERR_UNEXPECT));
        // byte extremes, raw control byte and an escape inside one string
        add_row(CH_LBRACK, 1'b0, 1'b0, '0);
        add_row(CH_QUOTE, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(CH_BSLASH, 1'b0, 1'b0, '0);
        add_row(CH_N, 1'b0, 1'b0, '0);
        add_row(CH_QUOTE, 1'b0, 1'b0, '0);
        add_row(CH_RBRACK, 1'b1, 1'b0, '0);
        // body cut right after a backslash
        add_row(CH_LBRACK, 1'b0, 1'b0, '0);
        add_row(CH_QUOTE, 1'b0, 1'b0, '0);
        add_row(CH_BSLASH, 1'b1, 1'b1, verdict(ERR_CUT_ESC));
        // unicode escape is rejected; the first error holds to the end
        add_row(CH_LBRACK, 1'b0, 1'b0, '0);
        add_row(CH_QUOTE, 1'b0, 1'b0, '0);
        add_row(CH_BSLASH, 1'b0, 1'b0, '0);
        add_row("u", 1'b0, 1'b1, '0);
        add_row(CH_RBRACK, 1'b1, 1'b1, verdict(ERR_BAD_ESC));
        // unterminated string whose final byte is also a character
        w            = verdict(ERR_UNTERM);
        w.char_valid = 1'b1;
        w.char_value = "a";
        add_row(CH_LBRACK, 1'b0, 1'b0, '0);
        add_row(CH_QUOTE, 1'b0, 1'b0, '0);
        add_row("a", 1'b1, 1'b1, w);
        // data after the closing bracket
        add_row(CH_LBRACK, 1'b0, 1'b0, '0);
        add_row(CH_RBRACK, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1, verdict(ERR_TRAILING));

        // hold reset, then release
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_byte(directed_rows[i].item.body_byte, directed_rows[i].item.final_byte,
                       directed_rows[i].fixed, directed_rows[i].want);

        // random bodies
        while (random_sent < RANDOM_BYTES)
        begin
            build_body();
            quiet_body = ($urandom_range(0, 3) == 0);
            foreach (body_q[i])
            begin
                offer_byte(body_q[i], i == body_q.size() - 1, 1'b0, '0);
                random_sent++;
                if (random_sent >= CALM_FROM)
                    calm_tail = 1'b1;
            end
        end
        byte_valid <= 1'b0;

        // drain outstanding results
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("json_string_array_parser regression: pass");
        else
            $display("json_string_array_parser regression: fail");
        $finish;
    end

endmodule
